// ===== rtl/core/bmp_pkg.sv =====
package bmp_pkg;

  // Channel and field widths
  localparam int CH_W       = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 12;
  localparam int LANES      = 3;

  // Quotient of a block mean always fits one channel
  localparam int QUO_W      = CH_W;
  localparam int STEP_W     = $clog2(QUO_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int BSIZE_W    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_SIZE   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [BSIZE_W-1:0]    RST_BLOCK_SIZE   = 7'd15;

  localparam int HEIGHT_LIMIT      = 4096;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int MAX_BLOCK_DEFAULT = 64;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0]      mean_red;
    logic [CH_W-1:0]      mean_green;
    logic [CH_W-1:0]      mean_blue;
    logic [OUT_COL_W-1:0] block_column;
    logic [ROW_W-1:0]     block_row;
    logic                 frame_last;
  } res_t;

  // Per-pixel control handed from the scan counters to the store
  typedef struct packed {
    logic                 emit;
    logic                 first_row;
    logic                 frame_last;
    logic [OUT_COL_W-1:0] block_column;
    logic [ROW_W-1:0]     block_row;
  } meta_t;

endpackage

// ===== rtl/core/bmp_stream_if.sv =====
interface bmp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bmp_cfg.sv =====
module bmp_cfg #(
  parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_last_o,
  output logic [bmp_pkg::ROW_W-1:0]      row_last_o,
  output logic [$clog2(MAX_BLOCK)-1:0]   blk_last_o,
  output logic                           restart_o
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int BLK_W = $clog2(MAX_BLOCK);
  localparam int ROW_W = bmp_pkg::ROW_W;

  logic [bmp_pkg::CFG_DATA_W-1:0] width_q, width_d;
  logic [bmp_pkg::CFG_DATA_W-1:0] height_q, height_d;
  logic [bmp_pkg::BSIZE_W-1:0]    bsize_q, bsize_d;

  // Decode register writes
  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    bsize_d   = bsize_q;
    restart_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bmp_pkg::CFG_IDX_IMAGE_WIDTH: begin
          width_d   = cfg_data_i;
          restart_o = 1'b1;
        end
        bmp_pkg::CFG_IDX_IMAGE_HEIGHT: begin
          height_d  = cfg_data_i;
          restart_o = 1'b1;
        end
        bmp_pkg::CFG_IDX_BLOCK_SIZE: begin
          bsize_d   = cfg_data_i[bmp_pkg::BSIZE_W-1:0];
          restart_o = 1'b1;
        end
        default: begin
          restart_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bmp_pkg::RST_IMAGE_WIDTH;
      height_q <= bmp_pkg::RST_IMAGE_HEIGHT;
      bsize_q  <= bmp_pkg::RST_BLOCK_SIZE;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      bsize_q  <= bsize_d;
    end
  end

  // Clamp sizes: zero acts as one, oversize acts as the limit
  always_comb begin
    if (width_q == '0) begin
      col_last_o = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      col_last_o = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last_o = COL_W'(width_q - 1'b1);
    end

    if (height_q == '0) begin
      row_last_o = '0;
    end else if (32'(height_q) > 32'(bmp_pkg::HEIGHT_LIMIT)) begin
      row_last_o = ROW_W'(bmp_pkg::HEIGHT_LIMIT - 1);
    end else begin
      row_last_o = ROW_W'(height_q - 1'b1);
    end

    if (bsize_q == '0) begin
      blk_last_o = '0;
    end else if (32'(bsize_q) > 32'(MAX_BLOCK)) begin
      blk_last_o = BLK_W'(MAX_BLOCK - 1);
    end else begin
      blk_last_o = BLK_W'(bsize_q - 1'b1);
    end
  end

endmodule

// ===== rtl/core/bmp_scan.sv =====
module bmp_scan #(
  parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  logic                                accept_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        col_last_i,
  input  logic [bmp_pkg::ROW_W-1:0]           row_last_i,
  input  logic [$clog2(MAX_BLOCK)-1:0]        blk_last_i,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr_o,
  output logic [2*($clog2(MAX_BLOCK)+1)-1:0]  div_o,
  output bmp_pkg::meta_t                      meta_o
);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int BLK_W     = $clog2(MAX_BLOCK);
  localparam int DIV_W     = 2 * (BLK_W + 1);
  localparam int ROW_W     = bmp_pkg::ROW_W;
  localparam int OUT_COL_W = bmp_pkg::OUT_COL_W;

  logic [COL_W-1:0] pix_col_q;
  logic [ROW_W-1:0] pix_row_q;
  logic [BLK_W-1:0] cwb_q;
  logic [BLK_W-1:0] rwb_q;
  logic [COL_W-1:0] blk_col_q;
  logic [ROW_W-1:0] blk_row_q;

  logic             line_end;
  logic             frame_end;
  logic             col_wrap;
  logic             row_wrap;
  logic [BLK_W:0]   cw_cnt;
  logic [BLK_W:0]   rw_cnt;

  // Classify the pixel at the current position
  always_comb begin
    line_end  = pix_col_q >= col_last_i;
    frame_end = pix_row_q >= row_last_i;
    col_wrap  = cwb_q >= blk_last_i;
    row_wrap  = rwb_q >= blk_last_i;
    cw_cnt    = {1'b0, cwb_q} + (BLK_W+1)'(1);
    rw_cnt    = {1'b0, rwb_q} + (BLK_W+1)'(1);

    addr_o              = blk_col_q;
    div_o               = DIV_W'(cw_cnt) * DIV_W'(rw_cnt);
    meta_o.emit         = (line_end || col_wrap) && (frame_end || row_wrap);
    meta_o.first_row    = rwb_q == '0;
    meta_o.frame_last   = line_end && frame_end;
    meta_o.block_column = OUT_COL_W'(blk_col_q);
    meta_o.block_row    = blk_row_q;
  end

  // Advance the raster position on each accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q <= '0;
      pix_row_q <= '0;
      cwb_q     <= '0;
      rwb_q     <= '0;
      blk_col_q <= '0;
      blk_row_q <= '0;
    end else if (restart_i) begin
      pix_col_q <= '0;
      pix_row_q <= '0;
      cwb_q     <= '0;
      rwb_q     <= '0;
      blk_col_q <= '0;
      blk_row_q <= '0;
    end else if (accept_i) begin
      if (line_end) begin
        pix_col_q <= '0;
        cwb_q     <= '0;
        blk_col_q <= '0;
        if (frame_end) begin
          pix_row_q <= '0;
          rwb_q     <= '0;
          blk_row_q <= '0;
        end else begin
          pix_row_q <= pix_row_q + 1'b1;
          if (row_wrap) begin
            rwb_q     <= '0;
            blk_row_q <= blk_row_q + 1'b1;
          end else begin
            rwb_q <= rwb_q + 1'b1;
          end
        end
      end else begin
        pix_col_q <= pix_col_q + 1'b1;
        if (col_wrap) begin
          cwb_q     <= '0;
          blk_col_q <= blk_col_q + 1'b1;
        end else begin
          cwb_q <= cwb_q + 1'b1;
        end
      end
    end
  end

  // Position never runs past the configured line or block
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_col_q <= col_last_i && cwb_q <= blk_last_i && rwb_q <= blk_last_i)
    else $error("scan position beyond configured size");

endmodule

// ===== rtl/core/bmp_accum.sv =====
module bmp_accum #(
  parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           restart_i,
  input  logic                                           accept_i,
  input  bmp_pkg::pix_t                                  pix_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                   addr_i,
  input  logic [2*($clog2(MAX_BLOCK)+1)-1:0]             div_i,
  input  bmp_pkg::meta_t                                 meta_i,
  output logic                                           start_o,
  output logic [bmp_pkg::LANES-1:0]
               [$clog2(MAX_BLOCK*MAX_BLOCK*255+1)-1:0]    sums_o,
  output logic [2*($clog2(MAX_BLOCK)+1)-1:0]             div_o,
  output bmp_pkg::meta_t                                 meta_o
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int BLK_W = $clog2(MAX_BLOCK);
  localparam int DIV_W = 2 * (BLK_W + 1);
  localparam int SUM_W = $clog2(MAX_BLOCK*MAX_BLOCK*255+1);
  localparam int LANES = bmp_pkg::LANES;
  localparam int ENT_W = LANES * SUM_W;

  // Line store: one entry of three channel sums per block column
  logic [ENT_W-1:0] mem_q [MAX_WIDTH];
  logic [ENT_W-1:0] rdata_q;

  logic             s1_valid_q;
  bmp_pkg::pix_t    pix_q;
  logic [COL_W-1:0] addr_q;
  logic [DIV_W-1:0] div_q;
  bmp_pkg::meta_t   meta_q;

  logic             fwd_valid_q;
  logic [COL_W-1:0] fwd_addr_q;
  logic [ENT_W-1:0] fwd_data_q;

  logic                              fwd_hit;
  logic [ENT_W-1:0]                  base;
  logic [LANES-1:0][SUM_W-1:0]       sums;
  logic [LANES-1:0][bmp_pkg::CH_W-1:0] px;
  logic [ENT_W-1:0]                  wdata;

  // Issue the read with the transaction, write back in the cycle after it
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_i];
    if (s1_valid_q) begin
      mem_q[addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      if (restart_i) begin
        fwd_valid_q <= 1'b0;
      end else if (s1_valid_q) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pix_q  <= pix_i;
      addr_q <= addr_i;
      div_q  <= div_i;
      meta_q <= meta_i;
    end
    if (s1_valid_q) begin
      fwd_addr_q <= addr_q;
      fwd_data_q <= wdata;
    end
  end

  // Forward the last write; the first line of a block row starts from zero
  always_comb begin
    fwd_hit = fwd_valid_q && (fwd_addr_q == addr_q);
    if (fwd_hit) begin
      base = fwd_data_q;
    end else if (meta_q.first_row) begin
      base = '0;
    end else begin
      base = rdata_q;
    end
    px[0] = pix_q.red;
    px[1] = pix_q.green;
    px[2] = pix_q.blue;
    for (int l = 0; l < LANES; l++) begin
      sums[l] = base[l*SUM_W +: SUM_W] + SUM_W'(px[l]);
    end
    wdata = meta_q.emit ? '0 : ENT_W'(sums);
  end

  assign start_o = s1_valid_q && meta_q.emit;
  assign sums_o  = sums;
  assign div_o   = div_q;
  assign meta_o  = meta_q;

  // A block-completing pixel holds off the next transaction
  a_no_accept_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_o |-> !accept_i)
    else $error("pixel accepted while a block mean is being issued");

  // Forwarding only follows a real write
  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_valid_q) |-> $past(s1_valid_q))
    else $error("forward entry set without a store write");

endmodule

// ===== rtl/core/bmp_div.sv =====
module bmp_div #(
  parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [bmp_pkg::LANES-1:0]
               [$clog2(MAX_BLOCK*MAX_BLOCK*255+1)-1:0]  sums_i,
  input  logic [2*($clog2(MAX_BLOCK)+1)-1:0]           div_i,
  input  bmp_pkg::meta_t                               meta_i,
  output logic                                         busy_o,
  bmp_stream_if.source                                 res_o
);
  localparam int SUM_W  = $clog2(MAX_BLOCK*MAX_BLOCK*255+1);
  localparam int LANES  = bmp_pkg::LANES;
  localparam int QUO_W  = bmp_pkg::QUO_W;
  localparam int STEP_W = bmp_pkg::STEP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } st_e;

  st_e               state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;

  logic [SUM_W-1:0]  rem_q [LANES];
  logic [QUO_W-1:0]  quo_q [LANES];
  logic [SUM_W-1:0]  rem_d [LANES];
  logic [QUO_W-1:0]  quo_d [LANES];
  logic [SUM_W-1:0]  dsh_q;
  logic [SUM_W-1:0]  div_q;
  bmp_pkg::meta_t    meta_q;
  bmp_pkg::res_t     out_data_q;

  logic              slot_free;
  logic              last_step;

  assign slot_free = !out_valid_q || res_o.ready;
  assign last_step = step_q == STEP_W'(QUO_W - 1);
  assign busy_o    = state_q != ST_IDLE;

  // One restoring step per cycle, three channels side by side
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (rem_q[l] >= dsh_q) begin
        rem_d[l] = rem_q[l] - dsh_q;
        quo_d[l] = {quo_q[l][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[l] = rem_q[l];
        quo_d[l] = {quo_q[l][QUO_W-2:0], 1'b0};
      end
    end
  end

  // Sequence the divide and hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise the result when the slot frees, drop it once taken
      if (state_q == ST_HOLD && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (start_i) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          step_q <= step_q + 1'b1;
          if (last_step) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= sums_i[l];
        quo_q[l] <= '0;
      end
      div_q  <= SUM_W'(div_i);
      dsh_q  <= SUM_W'(div_i) << (QUO_W - 1);
      meta_q <= meta_i;
    end else if (state_q == ST_RUN) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= rem_d[l];
        quo_q[l] <= quo_d[l];
      end
      dsh_q <= dsh_q >> 1;
    end
    if (state_q == ST_HOLD && slot_free) begin
      out_data_q.mean_red     <= quo_q[0];
      out_data_q.mean_green   <= quo_q[1];
      out_data_q.mean_blue    <= quo_q[2];
      out_data_q.block_column <= meta_q.block_column;
      out_data_q.block_row    <= meta_q.block_row;
      out_data_q.frame_last   <= meta_q.frame_last;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

  // A new divide only starts from idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("divide started while busy");

  // Every mean fits one channel, so the final remainders stay below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> (rem_q[0] < div_q) && (rem_q[1] < div_q) && (rem_q[2] < div_q))
    else $error("block sum exceeds channel range times divisor");

endmodule

// ===== rtl/core/block_mean_pixelizer_top.sv =====
// A block-completing pixel gives its mean after the store stage, the divider load, the
// eight divide steps and the output register. Throughput: one pixel per cycle through the
// line store read-modify-write (registered read, write-back with forwarding); such a pixel
// holds off the next pixel while the shared divider runs its eight steps, one bit per cycle.
// Reset: asynchronous, active low; sizes return to 640 x 480 with 15-pixel blocks. The
// store needs no clearing pass: the first line of each block row overwrites its entry.
module block_mean_pixelizer_top #(
  parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bmp_stream_if.sink                     pix_i,
  bmp_stream_if.source                   res_o
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int BLK_W = $clog2(MAX_BLOCK);
  localparam int DIV_W = 2 * (BLK_W + 1);
  localparam int SUM_W = $clog2(MAX_BLOCK*MAX_BLOCK*255+1);

  logic [COL_W-1:0]              col_last;
  logic [bmp_pkg::ROW_W-1:0]     row_last;
  logic [BLK_W-1:0]              blk_last;
  logic                          restart;
  logic                          accept;
  logic [COL_W-1:0]              scan_addr;
  logic [DIV_W-1:0]              scan_div;
  bmp_pkg::meta_t                scan_meta;
  logic                          div_start;
  logic [bmp_pkg::LANES-1:0][SUM_W-1:0] acc_sums;
  logic [DIV_W-1:0]              acc_div;
  bmp_pkg::meta_t                acc_meta;
  logic                          div_busy;

  // Take a pixel unless a block mean is on its way into the divider or the divider is busy
  assign pix_i.ready = !div_busy && !div_start;
  assign accept      = pix_i.valid && pix_i.ready;

  bmp_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .col_last_o  (col_last),
    .row_last_o  (row_last),
    .blk_last_o  (blk_last),
    .restart_o   (restart)
  );

  bmp_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .accept_i   (accept),
    .col_last_i (col_last),
    .row_last_i (row_last),
    .blk_last_i (blk_last),
    .addr_o     (scan_addr),
    .div_o      (scan_div),
    .meta_o     (scan_meta)
  );

  bmp_accum #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .accept_i  (accept),
    .pix_i     (pix_i.data),
    .addr_i    (scan_addr),
    .div_i     (scan_div),
    .meta_i    (scan_meta),
    .start_o   (div_start),
    .sums_o    (acc_sums),
    .div_o     (acc_div),
    .meta_o    (acc_meta)
  );

  bmp_div #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sums_i  (acc_sums),
    .div_i   (acc_div),
    .meta_i  (acc_meta),
    .busy_o  (div_busy),
    .res_o   (res_o)
  );

endmodule

// ===== tb/block_mean_pixelizer_top_test.sv =====
`timescale 1ns / 1ps

module block_mean_pixelizer_top_test;
  import bmp_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int LINE_ENTRIES  = MAX_WIDTH_DEFAULT;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PIXELS = 1300;
  localparam int REPORT_LIMIT  = 10;
  localparam int EXTREME_LINE  = 150;

  // Index past the register list; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    pix_t                  px;
    bit                    typed;
    res_t                  mean;
  } bench_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmp_stream_if #(.T(pix_t)) pix_if ();
  bmp_stream_if #(.T(res_t)) res_if ();

  block_mean_pixelizer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state: line store of channel sums, scan position, registers
  int unsigned red_sum   [LINE_ENTRIES];
  int unsigned green_sum [LINE_ENTRIES];
  int unsigned blue_sum  [LINE_ENTRIES];
  int unsigned scan_col, scan_row, col_in_block, row_in_block, mosaic_col, mosaic_row;
  int unsigned reg_width, reg_height, reg_block;

  res_t        mean_queue [$];
  bench_row_t  directed_rows [$];
  int unsigned mismatch_count, results_seen, pixels_sent, cfg_writes, random_pixels;
  int unsigned send_idle_pct, recv_idle_pct;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] channel_mean(input int unsigned sum,
                                                   input int unsigned cells);
    int unsigned quot;
    quot = sum / cells;
    return quot[CH_W-1:0];
  endfunction

  function automatic void restart_scan();
    for (int i = 0; i < LINE_ENTRIES; i++) begin
      red_sum[i]   = 0;
      green_sum[i] = 0;
      blue_sum[i]  = 0;
    end
    scan_col     = 0;
    scan_row     = 0;
    col_in_block = 0;
    row_in_block = 0;
    mosaic_col   = 0;
    mosaic_row   = 0;
  endfunction

  // Accumulate one pixel; return 1 with the block mean when it closes a block
  function automatic bit predict_block_mean(input pix_t px, output res_t mean);
    int unsigned w, h, b, slot, cells;
    bit          line_end, frame_end, at_right, at_bottom, emitted;
    w         = clamp_size(reg_width, MAX_WIDTH_DEFAULT);
    h         = clamp_size(reg_height, HEIGHT_LIMIT);
    b         = clamp_size(reg_block, MAX_BLOCK_DEFAULT);
    slot      = mosaic_col % LINE_ENTRIES;
    line_end  = scan_col >= w - 1;
    frame_end = scan_row >= h - 1;
    at_right  = line_end || (col_in_block >= b - 1);
    at_bottom = frame_end || (row_in_block >= b - 1);
    emitted   = at_right && at_bottom;
    mean      = '0;

    red_sum[slot]   += px.red;
    green_sum[slot] += px.green;
    blue_sum[slot]  += px.blue;

    if (emitted) begin
      cells             = (col_in_block + 1) * (row_in_block + 1);
      mean.mean_red     = channel_mean(red_sum[slot], cells);
      mean.mean_green   = channel_mean(green_sum[slot], cells);
      mean.mean_blue    = channel_mean(blue_sum[slot], cells);
      mean.block_column = mosaic_col[OUT_COL_W-1:0];
      mean.block_row    = mosaic_row[ROW_W-1:0];
      mean.frame_last   = line_end && frame_end;
      red_sum[slot]     = 0;
      green_sum[slot]   = 0;
      blue_sum[slot]    = 0;
    end

    // Advance the raster position
    if (line_end) begin
      scan_col     = 0;
      col_in_block = 0;
      mosaic_col   = 0;
      if (frame_end) begin
        scan_row     = 0;
        row_in_block = 0;
        mosaic_row   = 0;
      end else begin
        scan_row++;
        if (row_in_block >= b - 1) begin
          row_in_block = 0;
          mosaic_row++;
        end else begin
          row_in_block++;
        end
      end
    end else begin
      scan_col++;
      if (col_in_block >= b - 1) begin
        col_in_block = 0;
        mosaic_col++;
      end else begin
        col_in_block++;
      end
    end
    return emitted;
  endfunction

  function automatic bench_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    bench_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.idx      = idx;
    row.value    = value;
    return row;
  endfunction

  function automatic bench_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    bench_row_t row;
    row    = '{default: '0};
    row.px = {r, g, b};
    return row;
  endfunction

  // Single-pixel block: the mean is the pixel itself
  function automatic bench_row_t known_row(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [11:0] col,
                                           input logic [11:0] row_idx, input logic last);
    bench_row_t row;
    row       = '{default: '0};
    row.px    = {r, g, b};
    row.typed = 1'b1;
    row.mean  = {r, g, b, col, row_idx, last};
    return row;
  endfunction

  // Present one pixel, hold it until the transaction, then queue its expectation
  task automatic drive_pixel(input pix_t px, input bit typed, input res_t typed_mean);
    res_t mean;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
    if (predict_block_mean(px, mean) || typed) begin
      mean_queue.push_back(typed ? typed_mean : mean);
    end
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (mean_queue.size() != 0) @(posedge clk_i);
  endtask

  // Drain and let pixels that close no block leave the pipeline
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    bit hit;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
    hit = 1'b1;
    case (idx)
      CFG_IDX_IMAGE_WIDTH: begin
        reg_width = 32'(value);
      end
      CFG_IDX_IMAGE_HEIGHT: begin
        reg_height = 32'(value);
      end
      CFG_IDX_BLOCK_SIZE: begin
        reg_block = 32'(value[BSIZE_W-1:0]);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (hit) restart_scan();
    @(posedge clk_i);
  endtask

  // Stream random pixels; pick idle levels by how far the random part has come
  task automatic stream_pixels(input int unsigned count);
    pix_t px;
    for (int unsigned n = 0; n < count; n++) begin
      if (random_pixels < RANDOM_PIXELS / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 67;
      end else if (random_pixels < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      px.red   = CH_W'($urandom_range(255));
      px.green = CH_W'($urandom_range(255));
      px.blue  = CH_W'($urandom_range(255));
      drive_pixel(px, 1'b0, '0);
      random_pixels++;
      // Hold off the sender mid-frame until every mean has come back
      if (random_pixels == RANDOM_PIXELS / 2 || $urandom_range(299) == 0) wait_drained();
    end
  endtask

  // Result side: random stalls, compare each transaction with the oldest expectation
  initial begin
    res_t got, want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        results_seen++;
        if (mean_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Unexpected block mean rgb %0d %0d %0d block (%0d,%0d) last %0d",
                     got.mean_red, got.mean_green, got.mean_blue, got.block_column,
                     got.block_row, got.frame_last);
          end
        end else begin
          want = mean_queue.pop_front();
          if (got.mean_red !== want.mean_red || got.mean_green !== want.mean_green ||
              got.mean_blue !== want.mean_blue || got.block_column !== want.block_column ||
              got.block_row !== want.block_row || got.frame_last !== want.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("Block mean mismatch: expected rgb %0d %0d %0d block (%0d,%0d) last %0d",
                       want.mean_red, want.mean_green, want.mean_blue, want.block_column,
                       want.block_row, want.frame_last);
              $display("                     actual   rgb %0d %0d %0d block (%0d,%0d) last %0d",
                       got.mean_red, got.mean_green, got.mean_blue, got.block_column,
                       got.block_row, got.frame_last);
            end
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #30ms;
    $display("Timed out with %0d block means outstanding", mean_queue.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned           w_pick, h_pick, b_pick, frame_px, burst;
    logic [CFG_DATA_W-1:0] data;
    bit                    prev_write;

    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    send_idle_pct = 8;
    recv_idle_pct = 67;
    reg_width     = 32'(RST_IMAGE_WIDTH);
    reg_height    = 32'(RST_IMAGE_HEIGHT);
    reg_block     = 32'(RST_BLOCK_SIZE);
    restart_scan();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: two pixels that close nothing, dropped by the next write
    directed_rows.push_back(pix_row(8'h00, 8'hFF, 8'h80));
    directed_rows.push_back(pix_row(8'h7F, 8'h01, 8'hFE));
    // One-pixel frame: every pixel is its own block and ends the frame
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_WIDTH, 13'd1));
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_HEIGHT, 13'd1));
    directed_rows.push_back(cfg_row(CFG_IDX_BLOCK_SIZE, 13'd1));
    directed_rows.push_back(known_row(8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0, 1'b1));
    directed_rows.push_back(known_row(8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1));
    directed_rows.push_back(known_row(8'hA5, 8'h5A, 8'hC3, 12'd0, 12'd0, 1'b1));
    directed_rows.push_back(known_row(8'h5A, 8'hA5, 8'h3C, 12'd0, 12'd0, 1'b1));
    // Zero sizes act as one
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_WIDTH, 13'd0));
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_HEIGHT, 13'd0));
    directed_rows.push_back(cfg_row(CFG_IDX_BLOCK_SIZE, 13'd0));
    directed_rows.push_back(known_row(8'h12, 8'h34, 8'h56, 12'd0, 12'd0, 1'b1));
    // One line of three single-pixel blocks
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_WIDTH, 13'd3));
    directed_rows.push_back(known_row(8'hFF, 8'h00, 8'hFF, 12'd0, 12'd0, 1'b0));
    directed_rows.push_back(known_row(8'h00, 8'hFF, 8'h00, 12'd1, 12'd0, 1'b0));
    directed_rows.push_back(known_row(8'h80, 8'h40, 8'h20, 12'd2, 12'd0, 1'b1));
    // Oversize block over a 3 x 2 image; unused index written mid-frame
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_HEIGHT, 13'd2));
    directed_rows.push_back(cfg_row(CFG_IDX_BLOCK_SIZE, 13'h1FFF));
    directed_rows.push_back(pix_row(8'hFF, 8'hFF, 8'h00));
    directed_rows.push_back(pix_row(8'hFF, 8'hFE, 8'h01));
    directed_rows.push_back(pix_row(8'hFF, 8'hFF, 8'h80));
    directed_rows.push_back(cfg_row(CFG_IDX_UNUSED, 13'h1ABC));
    directed_rows.push_back(pix_row(8'hFE, 8'hFF, 8'hFF));
    directed_rows.push_back(pix_row(8'hFF, 8'hFF, 8'h7F));
    directed_rows.push_back(pix_row(8'hFF, 8'hFE, 8'h00));
    // 2 x 2 blocks over 3 x 3: partial last column and last row
    directed_rows.push_back(cfg_row(CFG_IDX_IMAGE_HEIGHT, 13'd3));
    directed_rows.push_back(cfg_row(CFG_IDX_BLOCK_SIZE, 13'd2));
    directed_rows.push_back(pix_row(8'h10, 8'hF0, 8'h33));
    directed_rows.push_back(pix_row(8'h21, 8'hE1, 8'h44));
    directed_rows.push_back(pix_row(8'h32, 8'hD2, 8'h55));
    directed_rows.push_back(pix_row(8'h43, 8'hC3, 8'h66));
    directed_rows.push_back(pix_row(8'h54, 8'hB4, 8'h77));
    directed_rows.push_back(pix_row(8'h65, 8'hA5, 8'h88));
    directed_rows.push_back(pix_row(8'h76, 8'h96, 8'h99));
    directed_rows.push_back(pix_row(8'h87, 8'h87, 8'hAA));
    directed_rows.push_back(pix_row(8'h98, 8'h78, 8'hBB));

    // Walk the table; writes happen only once the block is idle
    prev_write = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        if (!prev_write) quiesce();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        drive_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].mean);
      end
      prev_write = directed_rows[i].is_write;
    end

    // Random phases: new sizes, then whole frames or a frame cut short
    while (random_pixels < RANDOM_PIXELS) begin
      quiesce();
      case ($urandom_range(9))
        0:       w_pick = 0;
        1:       w_pick = $urandom_range(25, 70);
        default: w_pick = $urandom_range(1, 16);
      endcase
      case ($urandom_range(9))
        0:       h_pick = 0;
        1:       h_pick = $urandom_range(9, 20);
        default: h_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
        0:       b_pick = 0;
        1:       b_pick = $urandom_range(65, 127);
        2:       b_pick = $urandom_range(9, 64);
        default: b_pick = $urandom_range(1, 8);
      endcase
      if ($urandom_range(3) != 0) write_reg(CFG_IDX_IMAGE_WIDTH, CFG_DATA_W'(w_pick));
      if ($urandom_range(3) != 0) write_reg(CFG_IDX_IMAGE_HEIGHT, CFG_DATA_W'(h_pick));
      if ($urandom_range(3) != 0) begin
        data = CFG_DATA_W'(b_pick);
        // Upper data bits lie outside the block size register
        if ($urandom_range(3) == 0) begin
          data[CFG_DATA_W-1:BSIZE_W] = (CFG_DATA_W-BSIZE_W)'($urandom_range(1, 63));
        end
        write_reg(CFG_IDX_BLOCK_SIZE, data);
      end
      if ($urandom_range(7) == 0) begin
        write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom_range(8191)));
      end
      frame_px = clamp_size(reg_width, MAX_WIDTH_DEFAULT) * clamp_size(reg_height, HEIGHT_LIMIT);
      burst = (frame_px <= 160) ? frame_px * $urandom_range(1, 2) : $urandom_range(40, 160);
      if ($urandom_range(3) == 0) burst = $urandom_range(1, burst);
      stream_pixels(burst);
    end

    // Start of the widest line with one-pixel blocks, then of the tallest column
    // with the largest block
    quiesce();
    write_reg(CFG_IDX_IMAGE_WIDTH, 13'h1FFF);
    write_reg(CFG_IDX_IMAGE_HEIGHT, 13'd1);
    write_reg(CFG_IDX_BLOCK_SIZE, 13'd1);
    stream_pixels(EXTREME_LINE);
    quiesce();
    write_reg(CFG_IDX_IMAGE_WIDTH, 13'd1);
    write_reg(CFG_IDX_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(CFG_IDX_BLOCK_SIZE, 13'd64);
    stream_pixels(EXTREME_LINE);

    quiesce();
    $display("Streamed %0d pixels across %0d register writes; %0d block means compared.",
             pixels_sent, cfg_writes, results_seen);
    $display("Sizes ran from one-pixel frames to clamped 4096-pixel lines and columns.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bmp_pkg.sv
rtl/core/bmp_stream_if.sv
rtl/core/bmp_cfg.sv
rtl/core/bmp_scan.sv
rtl/core/bmp_accum.sv
rtl/core/bmp_div.sv
rtl/core/block_mean_pixelizer_top.sv
tb/block_mean_pixelizer_top_test.sv
